@@ design/swlm_pkg.sv @@
// shared constants and types for the sliding window loss monitor
// no dependencies; imported by swlm_hist and sliding_window_loss_monitor_core

package swlm_pkg;

  localparam int WINDOW_MAX = 64;                      // history depth in entries
  localparam int PTR_W      = $clog2(WINDOW_MAX);      // history index
  localparam int SUM_W      = PTR_W + 1;               // index plus occupancy before wrap
  localparam int OCC_W      = $clog2(WINDOW_MAX + 1);  // occupancy incl. full

  localparam int SEQ_W      = 64;  // sequence number
  localparam int WIN_W      = 7;   // window register and count fields
  localparam int THR_W      = 16;  // unsigned q0.16 threshold
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 24;  // 1+1+7+7+7+1 packed, byte aligned

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_THRESHOLD = 1'd1;

  // reset values of the registers
  localparam logic [WIN_W-1:0] WINDOW_RESET    = 7'd64;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd6554;

  // operation on the history fifo, at most one bit set
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } hist_cmd_t;

endpackage

@@ design/swlm_hist.sv @@
// circular history of accepted sequence numbers with oldest pointer and occupancy
// depends on swlm_pkg; registered read port, addressed by the next oldest pointer

module swlm_hist
  import swlm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  hist_cmd_t        cmd,
  input  logic [SEQ_W-1:0] wr_seq,
  output logic [SEQ_W-1:0] oldest_seq,
  output logic [OCC_W-1:0] occ
);

  logic [SEQ_W-1:0] store [WINDOW_MAX];
  logic [PTR_W-1:0] oldest_r, oldest_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [SEQ_W-1:0] rd_data_r;
  logic [SUM_W-1:0] slot_sum;
  logic [PTR_W-1:0] slot;
  logic [PTR_W-1:0] oldest_inc;

  // wrap of the oldest pointer
  assign oldest_inc = (oldest_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : oldest_r + 1'b1;

  // slot after the newest entry
  always_comb begin
    slot_sum = SUM_W'(oldest_r) + SUM_W'(occ_r);
    if (slot_sum >= SUM_W'(WINDOW_MAX)) begin
      slot_sum = slot_sum - SUM_W'(WINDOW_MAX);
    end
    slot = slot_sum[PTR_W-1:0];
  end

  always_comb begin
    oldest_nxt = oldest_r;
    occ_nxt    = occ_r;
    priority if (cmd.clear) begin
      oldest_nxt = '0;
      occ_nxt    = '0;
    end else if (cmd.pop) begin
      oldest_nxt = oldest_inc;
      occ_nxt    = occ_r - 1'b1;
    end else if (cmd.push) begin
      occ_nxt    = occ_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      occ_r    <= '0;
    end else begin
      oldest_r <= oldest_nxt;
      occ_r    <= occ_nxt;
    end
  end

  // store, written at the tail and read at the next oldest slot
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store[slot] <= wr_seq;
    end
    rd_data_r <= store[oldest_nxt];
  end

  assign oldest_seq = rd_data_r;
  assign occ        = occ_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(WINDOW_MAX))
    else $error("history occupancy beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (occ_r != OCC_W'(WINDOW_MAX)))
    else $error("push into a full history");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (occ_r != '0))
    else $error("pop from an empty history");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop && !cmd.clear) |=> (occ_r == $past(occ_r) - 1'b1))
    else $error("pop did not lower occupancy");

endmodule

@@ design/sliding_window_loss_monitor_core.sv @@
// top level of the sliding window loss monitor: sequencer, config and result register
// depends on swlm_pkg and swlm_hist
//
// The monitor takes one received 64-bit sequence number per input transaction
// and answers each with exactly one result transaction. It keeps up to 64
// recently accepted numbers in a circular history. A number at least a window
// behind the newest one clears the history and is accepted; any other number
// not above the newest is ignored (result all zero). An accepted number first
// drops stale history entries (a window or more behind it), one entry per
// clock through a single 64-bit subtract/compare, then is stored. The result
// carries expected, received and lost counts and a warning when
// lost/expected exceeds the q0.16 threshold, compared exactly by
// cross-multiplication (lost * 65536 > threshold * expected).
// Flow: in_tready is high only while the sequencer is idle; an accepted item
// passes through the check, the drop loop, the store step and the final step,
// and the drop loop over the history is the limiting part. A finished result
// sits in the output register while the next item is already accepted; if the
// previous result is still waiting there, the final step holds until it is
// taken. Ignored items go from the check straight to the final step. The user
// must write configuration through the plain write port (index 0 window_length,
// index 1 loss_threshold) only while idle; the block itself does not enforce it.

module sliding_window_loss_monitor_core
  import swlm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SEQ_W-1:0]      in_tdata,    // [63:0] seq
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [0] accepted, [1] history_cleared,
                                             // [8:2] expected_count,
                                             // [15:9] received_count,
                                             // [22:16] lost_count, [23] loss_warning
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an input transaction
  localparam logic [2:0] S_CHECK = 3'd1;  // far-behind / old / duplicate test
  localparam logic [2:0] S_POP   = 3'd2;  // drop stale entries, one per cycle
  localparam logic [2:0] S_PUSH  = 3'd3;  // store number, form counts
  localparam logic [2:0] S_FIN   = 3'd4;  // warning compare, load output register

  logic [2:0]            state_r, state_nxt;
  logic [SEQ_W-1:0]      seq_r;
  logic [SEQ_W-1:0]      newest_r;
  logic [WIN_W-1:0]      win_r;
  logic [THR_W-1:0]      thr_r;
  logic                  accepted_r;
  logic                  cleared_r;
  logic [WIN_W-1:0]      exp_r;
  logic [WIN_W-1:0]      rcv_r;
  logic [WIN_W-1:0]      lost_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  hist_cmd_t             hist_cmd;
  logic [SEQ_W-1:0]      oldest_seq;
  logic [OCC_W-1:0]      occ;

  // effective window: zero reads as one, above depth saturates
  logic [WIN_W-1:0]      win_eff;
  always_comb begin
    priority if (win_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_r > WIN_W'(WINDOW_MAX)) begin
      win_eff = WIN_W'(WINDOW_MAX);
    end else begin
      win_eff = win_r;
    end
  end

  // newest minus incoming, borrow in the top bit means incoming is newer
  logic [SEQ_W:0] behind;
  logic           newer;
  logic           far_behind;
  assign behind     = {1'b0, newest_r} - {1'b0, seq_r};
  assign newer      = behind[SEQ_W];
  assign far_behind = !newer && (behind[SEQ_W-1:0] != '0)
                      && (behind[SEQ_W-1:0] >= SEQ_W'(win_eff));

  // age of the oldest stored entry against the incoming number
  logic [SEQ_W-1:0] age;
  logic             stale;
  assign age   = seq_r - oldest_seq;
  assign stale = (occ != '0) && (age >= SEQ_W'(win_eff));

  // expected count: min(seq + 1, window) without wrapping seq + 1
  logic             seq_big;
  logic [WIN_W-1:0] expected;
  logic [WIN_W-1:0] received;
  logic [WIN_W-1:0] lost;
  assign seq_big  = (seq_r[SEQ_W-1:WIN_W] != '0)
                    || (seq_r[WIN_W-1:0] >= win_eff - 1'b1);
  assign expected = seq_big ? win_eff : seq_r[WIN_W-1:0] + 1'b1;
  assign received = WIN_W'(occ) + 1'b1;
  assign lost     = (expected >= received) ? expected - received : '0;

  // exact warning compare on registered counts
  logic [THR_W+WIN_W-1:0] lost_scaled;
  logic [THR_W+WIN_W-1:0] thr_scaled;
  logic                   warn;
  assign lost_scaled = {lost_r, {THR_W{1'b0}}};
  assign thr_scaled  = thr_r * exp_r;
  assign warn        = lost_scaled > thr_scaled;

  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    hist_cmd  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (occ == '0) begin
          state_nxt = S_POP;
        end else if (far_behind) begin
          hist_cmd.clear = 1'b1;
          state_nxt      = S_POP;
        end else if (!newer) begin
          state_nxt = S_FIN;   // old or duplicate, ignored
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (stale) begin
          hist_cmd.pop = 1'b1;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        hist_cmd.push = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      newest_r <= '0;
      win_r    <= WINDOW_RESET;
      thr_r    <= THRESHOLD_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LENGTH:  win_r <= cfg_wdata[WIN_W-1:0];
          REG_LOSS_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_PUSH) begin
        newest_r <= seq_r;
      end
    end
  end

  // item payload and result counts
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      seq_r     <= in_tdata;
      cleared_r <= 1'b0;
    end
    if (state_r == S_CHECK) begin
      accepted_r <= (occ == '0) || far_behind || newer;
      cleared_r  <= (occ != '0) && far_behind;
      exp_r      <= '0;
      rcv_r      <= '0;
      lost_r     <= '0;
    end
    if (state_r == S_PUSH) begin
      exp_r  <= expected;
      rcv_r  <= received;
      lost_r <= lost;
    end
  end

  // output register, decoupled from the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r <= {warn, lost_r, rcv_r, exp_r, cleared_r, accepted_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  swlm_hist u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (hist_cmd),
    .wr_seq     (seq_r),
    .oldest_seq (oldest_seq),
    .occ        (occ)
  );

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[OUT_DATA_W-1:1] == '0))
    else $error("ignored item with nonzero result fields");

  a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[15:9] + out_tdata[22:16] == out_tdata[8:2]))
    else $error("received plus lost differs from expected");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result loaded outside the final step");

  a_push_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> ($past(state_r) == S_POP))
    else $error("store without the stale-entry sweep");

endmodule

@@ tb/sliding_window_loss_monitor_core_test.sv @@
// self-checking testbench for sliding_window_loss_monitor_core
// depends on swlm_pkg and the monitor rtl; a scoreboard class predicts every result
`timescale 1ns / 100ps

module sliding_window_loss_monitor_core_test;
  import swlm_pkg::*;

  localparam int          NUM_PHASES      = 8;       // random phases, each with its own setting
  localparam int          ITEMS_PER_PHASE = 190;     // accepted numbers per random phase
  localparam int          SETTLE_CYCLES   = 80;      // wait after the last result for the sequencer to finish
  localparam int          MAX_REPORTS     = 40;      // cap on printed mismatches
  localparam int unsigned CYCLE_LIMIT     = 1500000;

  // one result transaction, laid out as out_tdata (last field in the lowest bit)
  typedef struct packed {
    logic             loss_warn;
    logic [WIN_W-1:0] lost_cnt;
    logic [WIN_W-1:0] rcvd_cnt;
    logic [WIN_W-1:0] exp_cnt;
    logic             cleared;
    logic             accepted;
  } loss_report_t;

  // predicts the loss report of each input transaction and checks results in order
  class loss_scoreboard;
    logic [SEQ_W-1:0] hist [WINDOW_MAX];  // circular history of accepted numbers
    int unsigned      oldest;
    int unsigned      fill;
    logic [SEQ_W-1:0] newest;
    logic [WIN_W-1:0] win_reg;
    logic [THR_W-1:0] thr_reg;
    loss_report_t     report_q [$];
    int unsigned      mismatches, results_seen, accepted_seen, cleared_seen;
    int unsigned      ignored_seen, warned_seen;

    function new();
      oldest  = 0;
      fill    = 0;
      newest  = '0;
      win_reg = WINDOW_RESET;
      thr_reg = THRESHOLD_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_WINDOW_LENGTH) win_reg = val[WIN_W-1:0];
      else if (idx == REG_LOSS_THRESHOLD) thr_reg = val[THR_W-1:0];
    endfunction

    // register zero acts as a window of one, values above the depth saturate
    function int unsigned eff_window();
      if (win_reg == 0) return 1;
      if (win_reg > WINDOW_MAX) return WINDOW_MAX;
      return win_reg;
    endfunction

    // returns 1 when the number is taken into the history
    function bit note_input(logic [SEQ_W-1:0] seq);
      int unsigned  w;
      int unsigned  expct;
      loss_report_t r;
      w = eff_window();
      r = '0;
      if (fill != 0) begin
        if (seq < newest && newest - seq >= SEQ_W'(w)) begin
          fill      = 0;
          oldest    = 0;
          r.cleared = 1'b1;
        end else if (seq <= newest) begin
          // old or duplicate: all-zero report
          report_q.push_back(r);
          return 1'b0;
        end
      end
      // drop entries a window or more behind the new number
      while (fill != 0 && seq - hist[oldest] >= SEQ_W'(w)) begin
        oldest = (oldest + 1) % WINDOW_MAX;
        fill--;
      end
      hist[(oldest + fill) % WINDOW_MAX] = seq;
      fill++;
      newest = seq;
      if (seq >= SEQ_W'(w - 1)) expct = w;
      else expct = int'(seq[WIN_W-1:0]) + 1;
      r.accepted  = 1'b1;
      r.exp_cnt   = WIN_W'(expct);
      r.rcvd_cnt  = WIN_W'(fill);
      r.lost_cnt  = (expct >= fill) ? WIN_W'(expct - fill) : '0;
      r.loss_warn = ({41'd0, r.lost_cnt, 16'd0} > 64'(thr_reg) * 64'(expct));
      report_q.push_back(r);
      return 1'b1;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(loss_report_t got);
      loss_report_t want;
      results_seen++;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = report_q.pop_front();
      if (want.accepted) accepted_seen++;
      else ignored_seen++;
      if (want.cleared) cleared_seen++;
      if (want.loss_warn) warned_seen++;
      check_field("accepted", want.accepted, got.accepted);
      check_field("history_cleared", want.cleared, got.cleared);
      check_field("expected_count", want.exp_cnt, got.exp_cnt);
      check_field("received_count", want.rcvd_cnt, got.rcvd_cnt);
      check_field("lost_count", want.lost_cnt, got.lost_cnt);
      check_field("loss_warning", want.loss_warn, got.loss_warn);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [SEQ_W-1:0]      in_tdata   = '0;           // [63:0] seq
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;                 // [0] accepted, [1] history_cleared,
                                                    // [8:2] expected_count,
                                                    // [15:9] received_count,
                                                    // [22:16] lost_count, [23] loss_warning
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  loss_scoreboard        sb = new();
  int                    idle_pct   = 20;           // chance of a stall burst, percent
  int                    stall_left = 0;
  int unsigned           cycle_cnt  = 0;
  int unsigned           settings_used = 0;
  logic [SEQ_W-1:0]      cursor     = '0;           // newest number of the current run

  sliding_window_loss_monitor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: ready drops in random bursts, none starting while idle_pct is zero
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor: every result transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(loss_report_t'(out_tdata));
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, sb.report_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one input transaction; a random idle gap may come first
  task automatic send_seq(input logic [SEQ_W-1:0] seq, output bit taken);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= seq;
    do @(posedge clk); while (!in_tready);
    taken = sb.note_input(seq);
    if (sb.fill != 0) cursor = sb.newest;
  endtask

  task automatic send_list(input logic [SEQ_W-1:0] seqs [$]);
    bit taken;
    foreach (seqs[i]) send_seq(seqs[i], taken);
  endtask

  // wait until every result is back and the sequencer has surely finished
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers are written only while the block is idle
  task automatic write_config(input int unsigned win, input int unsigned thr);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_wdata <= CFG_DATA_W'(win);
    @(posedge clk);
    sb.write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(win));
    cfg_index <= REG_LOSS_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    sb.write_reg(REG_LOSS_THRESHOLD, CFG_DATA_W'(thr));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly in-order runs with gaps, some reordering, far-behind jumps and noise
  function automatic logic [SEQ_W-1:0] next_seq();
    int unsigned w;
    int unsigned pick;
    w    = sb.eff_window();
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      cursor = cursor + 1;
      if ($urandom_range(0, 3) == 0) cursor = cursor + $urandom_range(0, 2 * w);
      return cursor;
    end
    if (pick < 78) return cursor - $urandom_range(0, w);        // duplicate or late
    if (pick < 84) return cursor - w - $urandom_range(0, 500);  // far behind, clears
    if (pick < 90) return {$urandom, $urandom};                 // noise
    // a new run from a fresh base: small, anywhere, or just below the top
    case ($urandom_range(0, 2))
      0:       cursor = $urandom_range(0, 200);
      1:       cursor = {$urandom, $urandom};
      default: cursor = {SEQ_W{1'b1}} - $urandom_range(0, 300);
    endcase
    return cursor;
  endfunction

  initial begin
    int unsigned win, thr;
    int          taken_cnt;
    bit          taken;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset setting (window 64, threshold 6554):
    // empty store, duplicate, losses with warning, late number, big gap that empties
    // the history, far-behind clear, exact window distance, largest number, wrap to zero
    send_list('{64'd0, 64'd0, 64'd1, 64'd5, 64'd3, 64'd200, 64'd100, 64'd164, 64'd163,
                64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE,
                64'hFFFF_FFFF_FFFF_FFFF});
    // window register zero acts as one, zero threshold
    write_config(0, 0);
    send_list('{64'd5, 64'd5, 64'd4, 64'd10});
    // window register above the depth saturates, largest threshold
    write_config(127, 65535);
    send_list('{64'd70, 64'd72, 64'd71, 64'd140});

    // random phases; the last two run without any idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin win = 64; thr = 6554;  end
        1:       begin win = 1;  thr = 0;     end
        2:       begin win = 2;  thr = 65535; end
        3:       begin win = 127; thr = $urandom_range(0, 65535); end
        4:       begin win = 0;  thr = $urandom_range(0, 65535); end
        default: begin win = $urandom_range(1, 64); thr = $urandom_range(0, 20000); end
      endcase
      write_config(win, thr);
      idle_pct  = (p >= NUM_PHASES - 2) ? 0 : $urandom_range(5, 40);
      taken_cnt = 0;
      while (taken_cnt < ITEMS_PER_PHASE) begin
        send_seq(next_seq(), taken);
        if (taken) taken_cnt++;
      end
    end

    drain();
    $display("covered %0d results over %0d settings: %0d accepted, %0d ignored",
             sb.results_seen, settings_used + 1, sb.accepted_seen, sb.ignored_seen);
    $display("history clears %0d, loss warnings %0d, mismatches %0d",
             sb.cleared_seen, sb.warned_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.report_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
